// ----- sv/grc_pkg.sv -----
// Shared types, constants and trig table for the grid ray caster.
// No dependencies; imported by every module of the block.
package grc_pkg;

    localparam int MAP_WIDTH     = 16;
    localparam int MAP_HEIGHT    = 16;
    localparam int CELL_SIZE     = 64;
    localparam int FIELD_OF_VIEW = 75;
    localparam int HALF_FOV      = FIELD_OF_VIEW / 2;
    localparam int CELL_Q8       = CELL_SIZE * 256;
    localparam int CELL_SHIFT    = $clog2(CELL_Q8);
    localparam int MAP_DEPTH     = 256;
    localparam int ADDR_W        = 8;
    localparam int CODE_W        = 4;

    localparam int DIV_NW  = 33;
    localparam int DIV_DW  = 28;
    localparam int SQ_W    = 54;
    localparam int ROOT_W  = SQ_W / 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [1:0] REG_MAX_STEPS    = 2'd0;
    localparam logic [1:0] REG_HEIGHT_LIMIT = 2'd1;
    localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

    typedef struct packed {
        logic              found;
        logic [CODE_W-1:0] code;
        logic [17:0]       x;
        logic [17:0]       y;
        logic [ROOT_W-1:0] span;
    } walk_res_t;

    localparam logic [16:0] SINE_Q16 [0:90] = '{
        17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850, 17'd7987,
        17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
        17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415, 17'd23486,
        17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767,
        17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
        17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
        17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
        17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684, 17'd54332,
        17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865, 17'd58393,
        17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584,
        17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
        17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65047, 17'd65177,
        17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
    };

    // t in 0..359, result Q16 signed
    function automatic logic signed [17:0] sin_deg(input logic [8:0] t);
        logic [6:0]         k;
        logic               neg;
        logic signed [17:0] mag;
        if (t < 9'd90) begin
            k   = t[6:0];
            neg = 1'b0;
        end else if (t < 9'd180) begin
            k   = 7'(9'd180 - t);
            neg = 1'b0;
        end else if (t < 9'd270) begin
            k   = 7'(t - 9'd180);
            neg = 1'b1;
        end else begin
            k   = 7'(9'd360 - t);
            neg = 1'b1;
        end
        mag = signed'({1'b0, SINE_Q16[k]});
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [17:0] cos_deg(input logic [8:0] t);
        return sin_deg((t >= 9'd270) ? 9'(t - 9'd270) : 9'(t + 9'd90));
    endfunction

    function automatic logic [17:0] clamp18(input logic signed [29:0] v);
        if (v < 0)
            return 18'd0;
        else if (v > 30'sd262143)
            return 18'd262143;
        else
            return v[17:0];
    endfunction

endpackage

// ----- sv/grid_raycast_wall_column.sv -----
// Grid ray caster, one wall column per cast transfer; top level.
// Map write: one cell per write transfer. Cast: setup, per direction a slope divide and a grid
// line walk, plus squares and the 27-step root on a hit, then pick, fisheye fix, the 33-step
// height divide and output; casts are taken one at a time.
// Reset: config to 8/320/20480, all map cells read empty (valid flags, no sweep).
// Uses grc_pkg, grc_map, grc_div, grc_sqrt.
module grid_raycast_wall_column
    import grc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cell_index[7:0] cell_code[11:8] player_x[29:12] player_y[47:30]
    // heading[56:48] column[63:57]
    input  logic [63:0] s_axis_tdata,
    // command[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // column_out[6:0] hit[7] vertical_side[8] wall_code[12:9] hit_x[30:13]
    // hit_y[48:31] distance[67:49] wall_height[77:68] line_top[86:78] pad[87]
    output logic [87:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    localparam int LC_W   = 21;
    localparam int PROD_W = 44;
    localparam int Q_W    = PROD_W - 16;
    localparam int OC_W   = 30;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_SETUP  = 16'h0002,
        S_WBEGIN = 16'h0004,
        S_SLOPE  = 16'h0008,
        S_LINE   = 16'h0010,
        S_MUL    = 16'h0020,
        S_LOOK   = 16'h0040,
        S_CHK    = 16'h0080,
        S_SQ1    = 16'h0100,
        S_SQ2    = 16'h0200,
        S_SQRT   = 16'h0400,
        S_PICK   = 16'h0800,
        S_CORR   = 16'h1000,
        S_HDIV   = 16'h2000,
        S_HWAIT  = 16'h4000,
        S_FIN    = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]  max_steps_reg;
    logic [9:0]  height_limit_reg;
    logic [19:0] height_scale_reg;

    logic        in_xfer, cast_xfer;
    logic [8:0]  hmod, ang_c, cam_c;
    logic [9:0]  asum, csum;

    logic [6:0]  column_reg;
    logic [17:0] px_reg, py_reg;
    logic [8:0]  ang_reg, cam_reg;
    logic signed [17:0] s_reg, c_reg, camcos_reg;

    logic        vert_reg;
    logic [17:0] main_p_reg, other_p_reg;
    logic        dm_neg_reg, dn_neg_reg;
    logic signed [17:0] dm_c, dn_c;
    logic [16:0] dm_abs, dn_abs;
    logic signed [22:0] slope_reg;
    logic signed [6:0]  line_reg;
    logic [4:0]  n_reg;
    logic signed [LC_W-1:0] lc_c, lcm_c, lc_reg, lcm_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_adj;
    logic signed [Q_W-1:0] q_c, q_reg;
    logic signed [OC_W-1:0] oc_c, oc_reg;
    logic signed [6:0]  cm_c;
    logic [15:0] co_u, cm_u, row_u, col_u;
    logic [31:0] idx_full;
    logic        look_ok_c, look_ok_reg;
    logic [LC_W-2:0] lcm_abs;
    logic [Q_W-2:0]  q_abs;
    logic [39:0] sqa_reg;
    logic        last_line;

    walk_res_t   h_res_reg, v_res_reg, best_reg;
    logic        side_reg;
    logic        hsel;
    logic [43:0] corr_prod_reg;
    logic [ROOT_W-1:0] corr_reg;
    logic [9:0]  height_reg;

    logic [CODE_W-1:0] rd_data;
    logic        rd_en;

    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic              div_done;
    logic [DIV_NW-1:0] div_quot;

    logic              sq_start;
    logic [SQ_W-1:0]   sq_in;
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;

    logic        m_valid_reg;
    logic [87:0] m_data_reg;
    logic        out_free;
    logic [18:0] dist_out;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cast_xfer     = in_xfer && (s_axis_tuser[0] == CMD_CAST);
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_steps_reg    <= 5'd8;
            height_limit_reg <= 10'd320;
            height_scale_reg <= 20'd20480;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_STEPS:    max_steps_reg    <= cfg_data[4:0];
                REG_HEIGHT_LIMIT: height_limit_reg <= cfg_data[9:0];
                REG_HEIGHT_SCALE: height_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ray and camera angles
    always_comb
    begin
        hmod  = (s_axis_tdata[56:48] >= 9'd360) ? 9'(s_axis_tdata[56:48] - 9'd360)
                                                : s_axis_tdata[56:48];
        asum  = 10'(hmod) + 10'(s_axis_tdata[63:57]) + 10'(360 - HALF_FOV);
        if (asum >= 10'd720)
            ang_c = 9'(asum - 10'd720);
        else if (asum >= 10'd360)
            ang_c = 9'(asum - 10'd360);
        else
            ang_c = asum[8:0];
        csum  = 10'(360 + HALF_FOV) - 10'(s_axis_tdata[63:57]);
        cam_c = (csum >= 10'd360) ? 9'(csum - 10'd360) : csum[8:0];
    end

    grc_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_xfer && (s_axis_tuser[0] == CMD_WRITE)),
        .wr_addr (s_axis_tdata[7:0]),
        .wr_data (s_axis_tdata[11:8]),
        .rd_en   (rd_en),
        .rd_addr (idx_full[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // walk setup
    always_comb
    begin
        dm_c   = vert_reg ? c_reg : s_reg;
        dn_c   = vert_reg ? s_reg : c_reg;
        dm_abs = dm_c[17] ? 17'(-dm_c) : dm_c[16:0];
        dn_abs = dn_c[17] ? 17'(-dn_c) : dn_c[16:0];
    end

    // grid line crossing
    always_comb
    begin
        lc_c     = LC_W'(line_reg) <<< CELL_SHIFT;
        lcm_c    = lc_c - LC_W'(signed'({1'b0, main_p_reg}));
        prod_adj = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
        q_c      = prod_adj[PROD_W-1:16];
        oc_c     = OC_W'(signed'({1'b0, other_p_reg})) + OC_W'(q_c);
        cm_c     = dm_neg_reg ? 7'(line_reg - 7'sd1) : line_reg;
        co_u     = 16'(oc_c[OC_W-2:CELL_SHIFT]);
        cm_u     = 16'(unsigned'(cm_c));
        row_u    = vert_reg ? co_u : cm_u;
        col_u    = vert_reg ? cm_u : co_u;
        idx_full = 32'(row_u) * 32'(MAP_WIDTH) + 32'(col_u);
        look_ok_c = !oc_c[OC_W-1] && !cm_c[6]
                    && (row_u < 16'(MAP_HEIGHT)) && (col_u < 16'(MAP_WIDTH))
                    && (idx_full < 32'(MAP_DEPTH));
        rd_en    = (state_reg == S_LOOK) && look_ok_c;
        lcm_abs  = lcm_reg[LC_W-1] ? (LC_W-1)'(-lcm_reg) : lcm_reg[LC_W-2:0];
        q_abs    = q_reg[Q_W-1] ? (Q_W-1)'(-q_reg) : q_reg[Q_W-2:0];
        last_line = (6'(n_reg) + 6'd1) >= 6'(max_steps_reg);
    end

    assign hsel = h_res_reg.found && (!v_res_reg.found || (h_res_reg.span <= v_res_reg.span));
    assign corr_reg = corr_prod_reg[16+ROOT_W-1:16];

    always_comb
    begin
        div_start = 1'b0;
        div_num   = {5'd0, height_scale_reg, 8'd0};
        div_den   = DIV_DW'(corr_reg);
        if (state_reg == S_WBEGIN)
        begin
            div_start = (dm_c != 18'sd0);
            div_num   = {dn_abs, 16'd0};
            div_den   = DIV_DW'(dm_abs);
        end
        else if (state_reg == S_HDIV)
            div_start = (corr_reg != '0);
    end

    grc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign sq_start = (state_reg == S_SQ2);
    assign sq_in    = SQ_W'(sqa_reg) + SQ_W'(q_abs) * SQ_W'(q_abs);

    grc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (cast_xfer) state_next = S_SETUP;
            S_SETUP:  state_next = S_WBEGIN;
            S_WBEGIN:
                if (dm_c == 18'sd0)
                    state_next = vert_reg ? S_PICK : S_WBEGIN;
                else
                    state_next = S_SLOPE;
            S_SLOPE:
                if (div_done)
                begin
                    if (max_steps_reg == 5'd0)
                        state_next = vert_reg ? S_PICK : S_WBEGIN;
                    else
                        state_next = S_LINE;
                end
            S_LINE:   state_next = S_MUL;
            S_MUL:    state_next = S_LOOK;
            S_LOOK:   state_next = S_CHK;
            S_CHK:
                if (look_ok_reg && (rd_data != '0))
                    state_next = S_SQ1;
                else if (last_line)
                    state_next = vert_reg ? S_PICK : S_WBEGIN;
                else
                    state_next = S_LINE;
            S_SQ1:    state_next = S_SQ2;
            S_SQ2:    state_next = S_SQRT;
            S_SQRT:   if (sq_done) state_next = vert_reg ? S_PICK : S_WBEGIN;
            S_PICK:   state_next = S_CORR;
            S_CORR:   state_next = best_reg.found ? S_HDIV : S_FIN;
            S_HDIV:   state_next = (corr_reg == '0) ? S_FIN : S_HWAIT;
            S_HWAIT:  if (div_done) state_next = S_FIN;
            S_FIN:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FIN && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (cast_xfer)
                begin
                    column_reg <= s_axis_tdata[63:57];
                    px_reg     <= s_axis_tdata[29:12];
                    py_reg     <= s_axis_tdata[47:30];
                    ang_reg    <= ang_c;
                    cam_reg    <= cam_c;
                end
            S_SETUP:
            begin
                s_reg      <= sin_deg(ang_reg);
                c_reg      <= cos_deg(ang_reg);
                camcos_reg <= cos_deg(cam_reg);
                vert_reg   <= 1'b0;
                h_res_reg  <= '0;
                v_res_reg  <= '0;
            end
            S_WBEGIN:
            begin
                main_p_reg  <= vert_reg ? px_reg : py_reg;
                other_p_reg <= vert_reg ? py_reg : px_reg;
                dm_neg_reg  <= dm_c[17];
                dn_neg_reg  <= dn_c[17];
                if (dm_c == 18'sd0)
                    vert_reg <= 1'b1;
            end
            S_SLOPE:
                if (div_done)
                begin
                    slope_reg <= (dm_neg_reg ^ dn_neg_reg) ? -signed'(div_quot[22:0])
                                                            : signed'(div_quot[22:0]);
                    line_reg  <= 7'(main_p_reg[17:CELL_SHIFT]) + 7'(!dm_neg_reg);
                    n_reg     <= '0;
                    if (max_steps_reg == 5'd0)
                        vert_reg <= 1'b1;
                end
            S_LINE:
            begin
                lc_reg  <= lc_c;
                lcm_reg <= lcm_c;
            end
            S_MUL:
                prod_reg <= PROD_W'(lcm_reg) * PROD_W'(slope_reg);
            S_LOOK:
            begin
                q_reg       <= q_c;
                oc_reg      <= oc_c;
                look_ok_reg <= look_ok_c;
            end
            S_CHK:
                if (look_ok_reg && (rd_data != '0))
                begin
                    if (vert_reg)
                    begin
                        v_res_reg.found <= 1'b1;
                        v_res_reg.code  <= rd_data;
                        v_res_reg.x     <= clamp18(OC_W'(lc_reg));
                        v_res_reg.y     <= clamp18(oc_reg);
                    end
                    else
                    begin
                        h_res_reg.found <= 1'b1;
                        h_res_reg.code  <= rd_data;
                        h_res_reg.x     <= clamp18(oc_reg);
                        h_res_reg.y     <= clamp18(OC_W'(lc_reg));
                    end
                end
                else
                begin
                    line_reg <= dm_neg_reg ? 7'(line_reg - 7'sd1) : 7'(line_reg + 7'sd1);
                    n_reg    <= n_reg + 5'd1;
                    if (last_line)
                        vert_reg <= 1'b1;
                end
            S_SQ1:
                sqa_reg <= 40'(lcm_abs) * 40'(lcm_abs);
            S_SQRT:
                if (sq_done)
                begin
                    if (vert_reg)
                        v_res_reg.span <= sq_root;
                    else
                        h_res_reg.span <= sq_root;
                    vert_reg <= 1'b1;
                end
            S_PICK:
            begin
                best_reg <= hsel ? h_res_reg : v_res_reg;
                side_reg <= !hsel && v_res_reg.found;
            end
            S_CORR:
                corr_prod_reg <= (!camcos_reg[17] && camcos_reg != 18'sd0)
                                 ? 44'(best_reg.span) * 44'(camcos_reg[16:0]) : 44'd0;
            S_HDIV:
                height_reg <= height_limit_reg;
            S_HWAIT:
                if (div_done)
                    height_reg <= (div_quot > DIV_NW'(height_limit_reg))
                                  ? height_limit_reg : div_quot[9:0];
            default: ;
        endcase
    end

    assign dist_out = (corr_reg > ROOT_W'(524287)) ? 19'd524287 : 19'(corr_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && out_free)
        begin
            if (best_reg.found)
                m_data_reg <= {1'b0,
                               9'(height_limit_reg[9:1] - height_reg[9:1]),
                               height_reg, dist_out,
                               best_reg.y, best_reg.x, best_reg.code,
                               side_reg, 1'b1, column_reg};
            else
                m_data_reg <= {1'b0, height_limit_reg[9:1], 10'd0, 19'd524287,
                               py_reg, px_reg, 4'd0, 1'b0, 1'b0, column_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- sv/grc_map.sv -----
// Map cell store: 4-bit codes, one write and one registered read port.
// Per-entry valid flags make unwritten cells read empty after reset. Uses grc_pkg.
module grc_map
    import grc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [CODE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CODE_W-1:0] rd_data
);

    logic [CODE_W-1:0]    mem [0:MAP_DEPTH-1];
    logic [MAP_DEPTH-1:0] valid_reg;
    logic [CODE_W-1:0]    rd_code_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_code_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_code_reg : '0;

endmodule

// ----- sv/grc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by slope and wall height. Uses grc_pkg.
module grc_div
    import grc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic              done,
    output logic [DIV_NW-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW:0]   shifted;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIV_DW'(shifted - {1'b0, den_reg}) : shifted[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ----- sv/grc_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
// Gives the raw hit distance. Uses grc_pkg.
module grc_sqrt
    import grc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SQ_W-1:0]   v_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W:0]    shifted;
    logic [REM_W:0]    trial;
    logic              fits;

    assign shifted = {rem_reg[REM_W-2:0], v_reg[SQ_W-1:SQ_W-2]};
    assign trial   = (REM_W + 1)'({root_reg, 2'b01});
    assign fits    = shifted >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= fits ? REM_W'(shifted - trial) : REM_W'(shifted);
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
